/* sv/slpq_pkg.sv */
// Shared types and codes of the sorted list priority queue.
package slpq_pkg;

  localparam int DefCapacity = 16;
  localparam int ValueW = 32;
  localparam int CmdW = 3;
  localparam int StatusW = 3;
  localparam int CountW = 5;

  localparam logic [CmdW-1:0] CMD_INSERT = 3'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CmdW-1:0] CMD_FIND   = 3'd2;
  localparam logic [CmdW-1:0] CMD_LIST   = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [StatusW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatusW-1:0] ST_REMOVED  = 3'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_FOUND    = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;
  localparam logic [StatusW-1:0] ST_LISTED   = 3'd5;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd6;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [ValueW-1:0]  value;
  } cell_ctl_t;

  typedef struct packed {
    logic take;
    logic shift;
    logic match;
  } cell_flags_t;

endpackage

/* sv/slpq_cell.sv */
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module slpq_cell (
  input  logic                                 clk_i,
  input  slpq_pkg::cell_ctl_t                  ctl_i,
  input  logic                                 occupied_i,
  input  logic                                 tail_i,
  input  logic                                 left_take_i,
  input  logic signed [slpq_pkg::ValueW-1:0]   left_value_i,
  input  logic signed [slpq_pkg::ValueW-1:0]   right_value_i,
  input  logic signed [slpq_pkg::ValueW-1:0]   wrap_value_i,
  output logic signed [slpq_pkg::ValueW-1:0]   value_o,
  output slpq_pkg::cell_flags_t                flags_o
);
  import slpq_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;

  always_comb begin
    flags_o.take  = !occupied_i || (value_q > ctl_i.value);
    flags_o.shift = occupied_i && (value_q >= ctl_i.value);
    flags_o.match = occupied_i && (value_q == ctl_i.value);
  end

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (left_take_i) begin
          value_d = left_value_i;
        end else if (flags_o.take) begin
          value_d = ctl_i.value;
        end
      end
      OP_REMOVE: begin
        if (flags_o.shift) begin
          value_d = right_value_i;
        end
      end
      OP_ROTATE: begin
        value_d = tail_i ? wrap_value_i : right_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* sv/sorted_list_priority_queue.sv */
// Top level of the sorted list priority queue built as a chain of cells.
// Insert, remove, find and clear are applied in exec once the output is free.
// List places the entries in order whenever the output is free, the chain rotating by one.
// A new item is accepted only once the previous one has placed all its results.
// Reset empties the table at once; entry storage itself is not cleared.
module sorted_list_priority_queue #(
  parameter int Capacity = slpq_pkg::DefCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: item_value[31:0].
  input  logic [slpq_pkg::ValueW-1:0]         s_axis_tdata,
  // Fields from bit 0: cmd[2:0].
  input  logic [slpq_pkg::CmdW-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: entry_value[31:0], entry_count[36:32], zero padding[39:37].
  output logic [39:0]                         m_axis_tdata,
  // Fields from bit 0: status[2:0].
  output logic [slpq_pkg::StatusW-1:0]        m_axis_tuser,
  output logic                                m_axis_tlast
);
  import slpq_pkg::*;

  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_e;

  state_e                   state_q, state_d;
  logic [CmdW-1:0]          cmd_q, cmd_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic                     m_valid_q, m_valid_d;
  logic [StatusW-1:0]       m_status_q, m_status_d;
  logic signed [ValueW-1:0] m_value_q, m_value_d;
  logic [CountW-1:0]        m_count_q, m_count_d;
  logic                     m_last_q, m_last_d;

  cell_ctl_t                ctl;
  logic signed [ValueW-1:0] cell_val [Capacity];
  cell_flags_t              cell_flags [Capacity];
  logic [Capacity-1:0]      match_vec;
  logic                     found;
  logic                     full;
  logic                     out_free;
  logic                     list_last;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                     left_take;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = '0;
    end else begin : g_mid
      assign left_take  = cell_flags[i-1].take;
      assign left_value = cell_val[i-1];
    end

    if (i == Capacity - 1) begin : g_end
      assign right_value = cell_val[i];
    end else begin : g_next
      assign right_value = cell_val[i+1];
    end

    assign match_vec[i] = cell_flags[i].match;

    slpq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occupied_i    (CW'(i) < cnt_q),
      .tail_i        (CW'(i) + CW'(1) == cnt_q),
      .left_take_i   (left_take),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .wrap_value_i  (cell_val[0]),
      .value_o       (cell_val[i]),
      .flags_o       (cell_flags[i])
    );
  end

  assign found     = |match_vec;
  assign full      = (cnt_q == CW'(Capacity));
  assign out_free  = !m_valid_q || m_axis_tready;
  assign list_last = (idx_q + CW'(1) == cnt_q);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_value_d  = m_value_q;
    m_count_d  = m_count_q;
    m_last_d   = m_last_q;
    ctl.op     = OP_HOLD;
    ctl.value  = val_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          val_d   = s_axis_tdata;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_INSERT, CMD_REMOVE, CMD_FIND, CMD_CLEAR: begin
            if (out_free) begin
              m_valid_d = 1'b1;
              m_value_d = '0;
              m_last_d  = 1'b1;
              m_count_d = CountW'(cnt_q);
              state_d   = S_IDLE;
              case (cmd_q)
                CMD_INSERT: begin
                  if (full) begin
                    m_status_d = ST_FULL;
                  end else begin
                    ctl.op     = OP_INSERT;
                    cnt_d      = cnt_q + CW'(1);
                    m_status_d = ST_INSERTED;
                    m_count_d  = CountW'(cnt_q + CW'(1));
                  end
                end
                CMD_REMOVE: begin
                  if (found) begin
                    ctl.op     = OP_REMOVE;
                    cnt_d      = cnt_q - CW'(1);
                    m_status_d = ST_REMOVED;
                    m_value_d  = val_q;
                    m_count_d  = CountW'(cnt_q - CW'(1));
                  end else begin
                    m_status_d = ST_NOTFOUND;
                  end
                end
                CMD_FIND: begin
                  m_status_d = found ? ST_FOUND : ST_NOTFOUND;
                end
                default: begin
                  cnt_d      = '0;
                  m_status_d = ST_CLEARED;
                  m_count_d  = '0;
                end
              endcase
            end
          end
          CMD_LIST: begin
            idx_d   = '0;
            state_d = (cnt_q == '0) ? S_IDLE : S_LIST;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_LIST: begin
        if (out_free) begin
          ctl.op     = OP_ROTATE;
          m_valid_d  = 1'b1;
          m_status_d = ST_LISTED;
          m_value_d  = cell_val[0];
          m_count_d  = CountW'(cnt_q);
          m_last_d   = list_last;
          idx_d      = idx_q + CW'(1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      m_valid_q  <= 1'b0;
      cmd_q      <= '0;
      val_q      <= '0;
      m_status_q <= '0;
      m_value_q  <= '0;
      m_count_q  <= '0;
      m_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      m_valid_q  <= m_valid_d;
      cmd_q      <= cmd_d;
      val_q      <= val_d;
      m_status_q <= m_status_d;
      m_value_q  <= m_value_d;
      m_count_q  <= m_count_d;
      m_last_q   <= m_last_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_count_q, m_value_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Capacity))
    else $error("entry count exceeds capacity");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_INSERT && full && out_free) |=> $stable(cnt_q))
    else $error("refused insert changed the entry count");

  a_list_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |=> $stable(cnt_q))
    else $error("listing changed the entry count");

  a_list_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (idx_q < cnt_q))
    else $error("list index ran past the held entries");
`endif

endmodule

/* verif/sorted_list_priority_queue_tb.sv */
// Self-checking stream testbench of the sorted list priority queue against a queue-based table model.
`timescale 1ns / 1ps

module sorted_list_priority_queue_tb;
  import slpq_pkg::*;

  localparam int Capacity = DefCapacity;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int WatchdogLimit = 5000;

  localparam logic [CmdW-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;

  localparam logic signed [ValueW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  count;
    logic               last;
  } pq_response_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ValueW-1:0]    s_axis_tdata = '0;
  logic [CmdW-1:0]      s_axis_tuser = CMD_FIND;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  logic                 m_axis_tlast;

  logic signed [ValueW-1:0] sorted_table[$];
  pq_response_t             due_responses[$];
  pq_response_t             want_resp;

  int  error_count = 0;
  int  items_sent = 0;
  int  responses_seen = 0;
  int  full_refusals = 0;
  int  idle_cycles = 0;
  int  hold_req_id = 0;
  int  hold_seen_id = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;

  sorted_list_priority_queue #(
    .Capacity(Capacity)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
    error_count++;
  endtask

  task automatic push_response(input logic [StatusW-1:0] status,
                               input logic [ValueW-1:0] value, input logic last);
    pq_response_t r;
    r.status = status;
    r.value  = value;
    r.count  = CountW'(sorted_table.size());
    r.last   = last;
    due_responses.push_back(r);
  endtask

  task automatic run_queue_command(input logic [CmdW-1:0] cmd,
                                   input logic signed [ValueW-1:0] value);
    int pos;
    pos = 0;
    case (cmd)
      CMD_INSERT: begin
        if (sorted_table.size() >= Capacity) begin
          full_refusals++;
          push_response(ST_FULL, '0, 1'b1);
        end else begin
          while (pos < sorted_table.size() && sorted_table[pos] <= value) pos++;
          sorted_table.insert(pos, value);
          push_response(ST_INSERTED, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        while (pos < sorted_table.size() && sorted_table[pos] != value) pos++;
        if (pos >= sorted_table.size()) begin
          push_response(ST_NOTFOUND, '0, 1'b1);
        end else begin
          sorted_table.delete(pos);
          push_response(ST_REMOVED, value, 1'b1);
        end
      end
      CMD_FIND: begin
        while (pos < sorted_table.size() && sorted_table[pos] != value) pos++;
        push_response((pos < sorted_table.size()) ? ST_FOUND : ST_NOTFOUND, '0, 1'b1);
      end
      CMD_LIST: begin
        for (int k = 0; k < sorted_table.size(); k++) begin
          push_response(ST_LISTED, sorted_table[k], k == sorted_table.size() - 1);
        end
      end
      CMD_CLEAR: begin
        sorted_table.delete();
        push_response(ST_CLEARED, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    int r;
    int tmp;
    r = $urandom_range(0, 99);
    if (r < 40 && sorted_table.size() != 0) begin
      return sorted_table[$urandom_range(0, sorted_table.size() - 1)];
    end else if (r < 70) begin
      tmp = $urandom_range(0, 15);
      tmp = tmp - 8;
      return tmp;
    end else if (r < 75) begin
      return ($urandom_range(0, 1) == 0) ? ValMin : ValMax;
    end else if (r < 80) begin
      return ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
    end
    return $urandom();
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic signed [ValueW-1:0] value);
    int gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    run_queue_command(cmd, value);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, ValMin);
    send_item(CMD_INSERT, ValMax);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_FIND, 32'sd0);
    send_item(CMD_FIND, 32'sd5);
    send_item(CMD_REMOVE, 32'sd7);
    send_item(CMD_REMOVE, 32'sd0);
    send_item(CMD_LIST, $urandom());
    send_item(CMD_FIND, ValMin);
    send_item(CMD_REMOVE, ValMax);
    send_item(CMD_LIST, $urandom());
  endtask

  task automatic test_empty_and_reserved();
    send_item(CMD_CLEAR, $urandom());
    send_item(CMD_LIST, $urandom());
    send_item(CMD_REMOVE, 32'sd1);
    send_item(CMD_FIND, -32'sd1);
    send_item(CMD_RSVD5, $urandom());
    send_item(CMD_RSVD6, $urandom());
    send_item(CMD_RSVD7, $urandom());
    send_item(CMD_LIST, $urandom());
  endtask

  // The output stalls for a long stretch while inserts keep coming, so the block backs up
  // and the inserts run past the table's capacity.
  task automatic test_fill_under_backpressure();
    wait_drained();
    hold_req_id <= hold_req_id + 1;
    send_item(CMD_CLEAR, $urandom());
    for (int k = 0; k < Capacity + 4; k++) send_item(CMD_INSERT, pick_value());
    send_item(CMD_LIST, $urandom());
    send_item(CMD_FIND, pick_value());
    wait_drained();
    send_item(CMD_REMOVE, sorted_table[0]);
    send_item(CMD_INSERT, pick_value());
    send_item(CMD_INSERT, pick_value());
  endtask

  task automatic test_random_traffic(input int n_items);
    int done = 0;
    int r;
    bit grow;
    logic [CmdW-1:0] cmd;
    while (done < n_items) begin
      grow = ((done / 30) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < (grow ? 55 : 30)) cmd = CMD_INSERT;
      else if (r < (grow ? 65 : 55)) cmd = CMD_REMOVE;
      else if (r < 77) cmd = CMD_FIND;
      else if (r < 88) cmd = CMD_LIST;
      else if (r < 92) cmd = CMD_CLEAR;
      else cmd = CmdW'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      send_item(cmd, pick_value());
      if (cmd <= CMD_CLEAR) done++;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id  <= hold_req_id;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      responses_seen++;
      if (due_responses.size() == 0) begin
        report_mismatch("response with none due", '0, m_axis_tdata);
      end else begin
        want_resp = due_responses.pop_front();
        if (m_axis_tuser != want_resp.status)
          report_mismatch("status", 40'(want_resp.status), 40'(m_axis_tuser));
        if (m_axis_tdata[31:0] != want_resp.value)
          report_mismatch("entry_value", 40'(want_resp.value), 40'(m_axis_tdata[31:0]));
        if (m_axis_tdata[36:32] != want_resp.count)
          report_mismatch("entry_count", 40'(want_resp.count), 40'(m_axis_tdata[36:32]));
        if (m_axis_tdata[39:37] != 3'd0)
          report_mismatch("padding", '0, 40'(m_axis_tdata[39:37]));
        if (m_axis_tlast != want_resp.last)
          report_mismatch("last", 40'(want_resp.last), 40'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_empty_and_reserved();
    test_fill_under_backpressure();
    test_random_traffic(120);
    no_idle = 1'b1;
    test_random_traffic(40);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (due_responses.size() != 0)
      report_mismatch("responses never received", '0, 40'(due_responses.size()));
    $display("Sent %0d command items and checked %0d responses.", items_sent, responses_seen);
    $display("Run included %0d full-table refusals and a %0d-cycle output stall.",
             full_refusals, HoldCycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
